>>> rtl/gbk_pkg.sv
// ----------------------------------------------------------------------------
// gbk_pkg
// Shared types and constants of the GBK text layout and glyph addresser.
// ----------------------------------------------------------------------------
package gbk_pkg;

	// Glyph kinds on the draw command
	localparam logic [1:0] KIND_HALF  = 2'd0;
	localparam logic [1:0] KIND_FLASH = 2'd1;
	localparam logic [1:0] KIND_BLANK = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_AREA_W    = 3'd2;
	localparam logic [2:0] REG_AREA_H    = 3'd3;
	localparam logic [2:0] REG_GLYPH_SIZE = 3'd4;
	localparam logic [2:0] REG_BASE_12   = 3'd5;
	localparam logic [2:0] REG_BASE_16   = 3'd6;
	localparam logic [2:0] REG_BASE_24   = 3'd7;

	// Byte codes
	localparam logic [7:0] BYTE_NUL      = 8'h00;
	localparam logic [7:0] BYTE_CR       = 8'd13;
	localparam logic [7:0] BYTE_HALF_MAX = 8'h80;
	localparam logic [7:0] LEAD_FIRST    = 8'h81;
	localparam logic [7:0] TRAIL_FIRST   = 8'h40;
	localparam logic [7:0] TRAIL_GAP     = 8'h7F;
	localparam logic [7:0] TRAIL_HIGH    = 8'h41;
	localparam logic [7:0] BYTE_FF       = 8'hFF;
	localparam logic [14:0] CODES_PER_ROW = 15'd190;

	// Supported full-width font sizes
	localparam logic [4:0] SIZE_12 = 5'd12;
	localparam logic [4:0] SIZE_16 = 5'd16;
	localparam logic [4:0] SIZE_24 = 5'd24;

	// Configuration register set
	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [11:0] area_width;
		logic [11:0] area_height;
		logic [4:0]  glyph_size;
		logic [31:0] base_12;
		logic [31:0] base_16;
		logic [31:0] base_24;
	} cfg_t;

	// Classified draw command between front and back
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  char_code;
		logic [6:0]  row_off;   // lead byte minus first lead code
		logic [7:0]  col_off;   // trail byte folded to table column
		logic [6:0]  nbytes;    // bitmap length, zero for half-width
	} cmd_t;

	// Bitmap length: ceil(size/8) * size
	function automatic logic [6:0] glyph_len(input logic [4:0] fs);
		logic [2:0]  rows;
		logic [7:0]  prod;
		rows = 3'((6'(fs) + 6'd7) >> 3);
		prod = 8'(rows) * 8'(fs);
		return prod[6:0];
	endfunction

endpackage

>>> rtl/gbk_front.sv
// ----------------------------------------------------------------------------
// gbk_front
// Cursor tracking and byte classification: keeps the text cursor, the
// pending lead byte and the halt flag, and pushes one command per glyph.
// ----------------------------------------------------------------------------
module gbk_front (
	input  logic          clk,
	input  logic          arst_n,
	input  gbk_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    text_byte,
	input  logic          new_string,
	output logic          push,
	output gbk_pkg::cmd_t cmd
);

	logic [15:0] cursor_x_q, cursor_y_q;
	logic        lead_pending_q, skip_next_q, halted_q;
	logic [7:0]  lead_byte_q;

	logic [15:0] cx_e, cy_e;
	logic        lead_e, skip_e, halted_e;

	logic [4:0]  fs;
	logic [3:0]  half;
	logic [4:0]  step;
	logic signed [15:0] right, bottom;
	logic        wrap, no_fit;
	logic [15:0] cx_w, cy_w;
	logic        sized, bad_pair;
	logic [7:0]  trail;

	logic [15:0] cx_d, cy_d;
	logic        lead_d, skip_d, halted_d;

	// State as seen by this byte, after a new string restart
	assign cx_e     = new_string ? {4'd0, cfg.origin_x} : cursor_x_q;
	assign cy_e     = new_string ? {4'd0, cfg.origin_y} : cursor_y_q;
	assign lead_e   = new_string ? 1'b0 : lead_pending_q;
	assign skip_e   = new_string ? 1'b0 : skip_next_q;
	assign halted_e = new_string ? 1'b0 : halted_q;

	assign fs    = cfg.glyph_size;
	assign half  = fs[4:1];
	assign step  = lead_e ? fs : {1'b0, half};
	assign trail = text_byte;

	// Wrap and bottom checks, signed so a negative limit always trips
	assign right  = signed'({4'd0, cfg.origin_x}) + signed'({4'd0, cfg.area_width})
		- signed'({11'd0, step});
	assign wrap   = signed'({1'b0, cx_e}) > 17'(right);
	assign cx_w   = wrap ? {4'd0, cfg.origin_x} : cx_e;
	assign cy_w   = wrap ? cy_e + {11'd0, fs} : cy_e;
	assign bottom = signed'({4'd0, cfg.origin_y}) + signed'({4'd0, cfg.area_height})
		- signed'({11'd0, fs});
	assign no_fit = signed'({1'b0, cy_w}) > 17'(bottom);

	assign sized    = (fs == gbk_pkg::SIZE_12) || (fs == gbk_pkg::SIZE_16)
		|| (fs == gbk_pkg::SIZE_24);
	assign bad_pair = (trail < gbk_pkg::TRAIL_FIRST) || (trail == gbk_pkg::BYTE_FF)
		|| (lead_byte_q == gbk_pkg::BYTE_FF);

	// Byte handling
	always_comb begin
		logic [7:0] row8;
		logic [7:0] col8;
		cx_d     = cx_e;
		cy_d     = cy_e;
		lead_d   = lead_e;
		skip_d   = skip_e;
		halted_d = halted_e;
		push     = 1'b0;
		row8     = lead_byte_q - gbk_pkg::LEAD_FIRST;
		col8     = (trail < gbk_pkg::TRAIL_GAP) ? trail - gbk_pkg::TRAIL_FIRST
			: trail - gbk_pkg::TRAIL_HIGH;
		cmd           = '0;
		cmd.pos_x     = cx_w;
		cmd.pos_y     = cy_w;
		if (halted_e) begin
			// ignore everything until a new string
		end else if (text_byte == gbk_pkg::BYTE_NUL) begin
			halted_d = 1'b1;
			lead_d   = 1'b0;
			skip_d   = 1'b0;
		end else if (skip_e) begin
			skip_d = 1'b0;
		end else if (lead_e) begin
			lead_d = 1'b0;
			cx_d   = cx_w;
			cy_d   = cy_w;
			if (no_fit) begin
				halted_d = 1'b1;
			end else begin
				push       = sized;
				cmd.nbytes = gbk_pkg::glyph_len(fs);
				if (bad_pair) begin
					cmd.kind = gbk_pkg::KIND_BLANK;
				end else begin
					cmd.kind    = gbk_pkg::KIND_FLASH;
					cmd.row_off = row8[6:0];
					cmd.col_off = col8;
				end
				cx_d = cx_w + {11'd0, fs};
			end
		end else if (text_byte > gbk_pkg::BYTE_HALF_MAX) begin
			lead_d = 1'b1;
		end else begin
			cx_d = cx_w;
			cy_d = cy_w;
			if (no_fit) begin
				halted_d = 1'b1;
			end else if (text_byte == gbk_pkg::BYTE_CR) begin
				cy_d   = cy_w + {11'd0, fs};
				cx_d   = {4'd0, cfg.origin_x};
				skip_d = 1'b1;
			end else begin
				push          = 1'b1;
				cmd.kind      = gbk_pkg::KIND_HALF;
				cmd.char_code = text_byte;
				cx_d          = cx_w + {12'd0, half};
			end
		end
		push = push && accept;
	end

	// Cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			lead_pending_q <= 1'b0;
			skip_next_q    <= 1'b0;
			halted_q       <= 1'b0;
			lead_byte_q    <= '0;
		end else if (accept) begin
			cursor_x_q     <= cx_d;
			cursor_y_q     <= cy_d;
			lead_pending_q <= lead_d;
			skip_next_q    <= skip_d;
			halted_q       <= halted_d;
			if (!halted_e && !skip_e && !lead_e && text_byte > gbk_pkg::BYTE_HALF_MAX) begin
				lead_byte_q <= text_byte;
			end
		end
	end

endmodule

>>> rtl/gbk_queue.sv
// ----------------------------------------------------------------------------
// gbk_queue
// Small command FIFO between the classifying front and the address back.
// ----------------------------------------------------------------------------
module gbk_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gbk_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output gbk_pkg::cmd_t head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	gbk_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> head_valid)
		else $error("full queue without head word");
`endif

endmodule

>>> rtl/gbk_back.sv
// ----------------------------------------------------------------------------
// gbk_back
// Glyph address pipeline: table slot, times bitmap length, plus font base,
// ending in the output register.
// ----------------------------------------------------------------------------
module gbk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  gbk_pkg::cfg_t cfg,
	input  logic          head_valid,
	input  gbk_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    glyph_kind,
	output logic [15:0]   pos_x,
	output logic [15:0]   pos_y,
	output logic [7:0]    char_code,
	output logic [31:0]   glyph_address,
	output logic [6:0]    glyph_bytes
);

	logic          adv;
	logic          valid_s1, valid_s2;
	gbk_pkg::cmd_t cmd_s1, cmd_s2;
	logic [14:0]   slot_s1;
	logic [21:0]   offs_s2;
	logic [31:0]   base;

	// Whole pipeline moves when the output slot frees
	assign adv = !out_valid || out_ready;
	assign pop = adv && head_valid;

	always_comb begin
		case (cfg.glyph_size)
			gbk_pkg::SIZE_12: base = cfg.base_12;
			gbk_pkg::SIZE_16: base = cfg.base_16;
			default:          base = cfg.base_24;
		endcase
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= head_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// table slot: row * 190 + column
			cmd_s1  <= head_cmd;
			slot_s1 <= 15'(head_cmd.row_off) * gbk_pkg::CODES_PER_ROW
				+ 15'(head_cmd.col_off);
			// byte offset into the table
			cmd_s2  <= cmd_s1;
			offs_s2 <= 22'(slot_s1) * 22'(cmd_s1.nbytes);
			// final command
			glyph_kind    <= cmd_s2.kind;
			pos_x         <= cmd_s2.pos_x;
			pos_y         <= cmd_s2.pos_y;
			char_code     <= cmd_s2.char_code;
			glyph_bytes   <= cmd_s2.nbytes;
			glyph_address <= (cmd_s2.kind == gbk_pkg::KIND_FLASH)
				? base + {10'd0, offs_s2} : 32'd0;
		end
	end

`ifndef SYNTHESIS
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (glyph_kind == gbk_pkg::KIND_HALF || glyph_kind == gbk_pkg::KIND_FLASH
			|| glyph_kind == gbk_pkg::KIND_BLANK))
		else $error("undefined glyph kind");
	a_half_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_kind == gbk_pkg::KIND_HALF |-> glyph_address == 32'd0
			&& glyph_bytes == 7'd0)
		else $error("half-width command with bitmap fields");
	a_full_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glyph_kind != gbk_pkg::KIND_HALF |-> char_code == 8'd0)
		else $error("full-width command with char code");
	a_pop_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && (!out_valid || out_ready))
		else $error("pop while pipeline stalled");
`endif

endmodule

>>> rtl/gbk_text_layout_glyph_addresser.sv
// ----------------------------------------------------------------------------
// gbk_text_layout_glyph_addresser
// Lays out a GBK byte stream in a text area and issues draw commands with
// the font flash address of each valid full-width glyph.
// ----------------------------------------------------------------------------
//  channel  | handshake                       | word
//  ---------+---------------------------------+---------------------------------
//  input    | in_valid / in_ready             | text_byte, new_string
//  output   | out_valid / out_ready           | glyph_kind, pos_x, pos_y,
//           |                                 | char_code, glyph_address, glyph_bytes
//  config   | cfg_we (no wait)                | cfg_index, cfg_data
//
//  One byte per cycle while in_ready is high; the front updates the cursor
//  in the cycle it takes a byte. Its command passes the command queue, the slot
//  multiply and the length multiply, then the base add into the output register.
//  in_ready drops only when the command queue is full; the back stalls as a
//  whole on out_ready. Reset sets registers to defaults and the cursor to the
//  origin; there is no clearing pass.
// ----------------------------------------------------------------------------
module gbk_text_layout_glyph_addresser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        new_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  glyph_kind,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [7:0]  char_code,
	output logic [31:0] glyph_address,
	output logic [6:0]  glyph_bytes
);

	gbk_pkg::cfg_t cfg_q;
	gbk_pkg::cmd_t push_cmd, head_cmd;
	logic          push, pop, full, head_valid, accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= 12'd0;
			cfg_q.origin_y    <= 12'd0;
			cfg_q.area_width  <= 12'd320;
			cfg_q.area_height <= 12'd240;
			cfg_q.glyph_size  <= 5'd16;
			cfg_q.base_12     <= 32'd0;
			cfg_q.base_16     <= 32'd0;
			cfg_q.base_24     <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				gbk_pkg::REG_ORIGIN_X:   cfg_q.origin_x    <= cfg_data[11:0];
				gbk_pkg::REG_ORIGIN_Y:   cfg_q.origin_y    <= cfg_data[11:0];
				gbk_pkg::REG_AREA_W:     cfg_q.area_width  <= cfg_data[11:0];
				gbk_pkg::REG_AREA_H:     cfg_q.area_height <= cfg_data[11:0];
				gbk_pkg::REG_GLYPH_SIZE: cfg_q.glyph_size  <= cfg_data[4:0];
				gbk_pkg::REG_BASE_12:    cfg_q.base_12     <= cfg_data;
				gbk_pkg::REG_BASE_16:    cfg_q.base_16     <= cfg_data;
				gbk_pkg::REG_BASE_24:    cfg_q.base_24     <= cfg_data;
				default: ;
			endcase
		end
	end

	gbk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.text_byte  (text_byte),
		.new_string (new_string),
		.push       (push),
		.cmd        (push_cmd)
	);

	gbk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	gbk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.glyph_kind    (glyph_kind),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.char_code     (char_code),
		.glyph_address (glyph_address),
		.glyph_bytes   (glyph_bytes)
	);

endmodule
